>>> hdl/isometric_edge_line_rasterizer_unit_macros.svh
// Assertion macros of the rasterizer RTL.
`ifndef ISOMETRIC_EDGE_LINE_RASTERIZER_UNIT_MACROS_SVH
`define ISOMETRIC_EDGE_LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IELR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IELR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ielr_pkg.sv
// ----------------------------------------------------------------------------
// ielr_pkg
// Widths, constants and helper functions of the isometric edge rasterizer.
// ----------------------------------------------------------------------------
package ielr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 16;

    // Positions and deltas need FRAC_BITS + 23 bits; one spare bit is kept.
    localparam int POS_W  = FRAC_BITS + 24;
    localparam int STEP_W = FRAC_BITS + 4;
    localparam int SPAN_W = 24;
    localparam int CNT_W  = $clog2(POS_W + 1);

    // Shared multiplier operands and product.
    localparam int MA_W   = 21;
    localparam int MB_W   = 17;
    localparam int PROD_W = MA_W + MB_W;
    localparam int EXT_W  = (PROD_W > POS_W) ? PROD_W : POS_W;

    localparam int Q_UP_SH = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
    localparam int Q_DN_SH = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
    localparam logic signed [EXT_W-1:0] Q_DN_DIV = EXT_W'(1) <<< Q_DN_SH;

    localparam int XS_W = 18;   // scaled grid coordinate, unsigned
    localparam int ZS_W = 19;   // scaled height, signed

    localparam logic [23:0] COLOR_HEIGHT = 24'h42f5a1;
    localparam logic [23:0] COLOR_FLAT   = 24'hffffff;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y      = 3'd5;

    localparam logic signed [POS_W-1:0] COORD_HI = POS_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [POS_W-1:0] COORD_LO = POS_W'(-(64'sd1 <<< (COORD_BITS - 1)));

    // Converts a Q23.14 product to FRAC_BITS fraction bits, truncating toward zero.
    function automatic logic signed [POS_W-1:0] from_q14(input logic signed [PROD_W-1:0] v);
        logic signed [EXT_W-1:0] w;
        w = EXT_W'(v);
        if (FRAC_BITS >= 14)
            w = w <<< Q_UP_SH;
        else
            w = w / Q_DN_DIV;
        return w[POS_W-1:0];
    endfunction

    // Integer part truncated toward zero, then saturated to COORD_BITS.
    function automatic logic [COORD_BITS-1:0] pixel_coord(input logic signed [POS_W-1:0] pos);
        logic signed [POS_W-1:0] q;
        q = pos >>> FRAC_BITS;
        if (pos[POS_W-1] && (pos[FRAC_BITS-1:0] != '0))
            q = q + POS_W'(1);
        if (q > COORD_HI)
            q = COORD_HI;
        else if (q < COORD_LO)
            q = COORD_LO;
        return q[COORD_BITS-1:0];
    endfunction

endpackage

>>> hdl/isometric_edge_line_rasterizer_unit.sv
// Edge load: ten multiplies on one shared multiplier, then the add, difference and
//   span steps and two bit-serial divisions; a zero span skips the divisions.
// Tick: one per cycle while no edge load is in progress and the output register
//   is free or being drained; the pixel appears the cycle after the tick beat.
// Reset: asynchronous, active low; all but the datapath registers get reset values.
// ----------------------------------------------------------------------------
// isometric_edge_line_rasterizer_unit
// Projects a grid edge isometrically and walks it with a fixed-point DDA.
// ----------------------------------------------------------------------------
`include "isometric_edge_line_rasterizer_unit_macros.svh"

module isometric_edge_line_rasterizer_unit
    import ielr_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [9:0]                   col_start,
    input  logic [9:0]                   row_start,
    input  logic [9:0]                   col_end,
    input  logic [9:0]                   row_end,
    input  logic signed [11:0]           height_start,
    input  logic signed [11:0]           height_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic [23:0]                  color,
    output logic                         last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [15:0]                  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ADD, ST_DIFF, ST_SPAN, ST_DIVX, ST_DIVY
    } state_t;

    typedef enum logic [3:0] {
        M_X0, M_Y0, M_X1, M_Y1, M_Z0, M_Z1, M_PX0, M_PY0, M_PX1, M_PY1
    } mstep_t;

    state_t state_reg;
    mstep_t mstep_reg;
    logic   div_started_reg;

    // Configuration
    logic [7:0]         unit_size_reg;
    logic signed [7:0]  height_scale_reg;
    logic signed [15:0] cos_angle_reg;
    logic signed [15:0] sin_angle_reg;
    logic signed [12:0] shift_x_reg;
    logic signed [12:0] shift_y_reg;

    // Captured edge and setup intermediates
    logic [9:0]                col0_reg, row0_reg, col1_reg, row1_reg;
    logic signed [11:0]        h0_reg, h1_reg;
    logic [XS_W-1:0]           x0_reg, y0_reg, x1_reg, y1_reg;
    logic signed [ZS_W-1:0]    z0_reg, z1_reg;
    logic signed [PROD_W-1:0]  ppx0_reg, ppy0_reg, ppx1_reg, ppy1_reg;
    logic signed [POS_W-1:0]   end_x_reg, end_y_reg;
    logic signed [POS_W-1:0]   dx_reg, dy_reg;
    logic [SPAN_W-1:0]         span_reg;

    // Walk state
    logic signed [POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic signed [STEP_W-1:0]  step_x_reg, step_y_reg;
    logic [SPAN_W-1:0]         left_reg;
    logic [23:0]               edge_color_reg;

    // Output register
    logic                      out_valid_reg;
    logic [COORD_BITS-1:0]     pixel_x_reg, pixel_y_reg;
    logic [23:0]               color_reg;
    logic                      last_reg;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic                      in_beat;
    logic                      emit;
    logic [POS_W-1:0]          mag_x, mag_y, mag_m;
    logic                      div_start;
    logic                      div_busy;
    logic                      div_done;
    logic [POS_W-1:0]          div_dividend;
    logic [POS_W-1:0]          div_quo;
    logic [STEP_W-1:0]         quo_trunc;
    logic signed [STEP_W-1:0]  step_new;
    logic signed [POS_W-1:0]   shift_xf, shift_yf;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_beat   = in_valid && in_ready;
    assign emit      = in_beat && cmd && (left_reg != '0);

    // Shared multiplier operand selection
    always_comb
    begin
        unique case (mstep_reg)
            M_X0:
            begin
                mul_a = MA_W'(signed'({1'b0, col0_reg}));
                mul_b = MB_W'(signed'({1'b0, unit_size_reg}));
            end
            M_Y0:
            begin
                mul_a = MA_W'(signed'({1'b0, row0_reg}));
                mul_b = MB_W'(signed'({1'b0, unit_size_reg}));
            end
            M_X1:
            begin
                mul_a = MA_W'(signed'({1'b0, col1_reg}));
                mul_b = MB_W'(signed'({1'b0, unit_size_reg}));
            end
            M_Y1:
            begin
                mul_a = MA_W'(signed'({1'b0, row1_reg}));
                mul_b = MB_W'(signed'({1'b0, unit_size_reg}));
            end
            M_Z0:
            begin
                mul_a = MA_W'(h0_reg);
                mul_b = MB_W'(height_scale_reg);
            end
            M_Z1:
            begin
                mul_a = MA_W'(h1_reg);
                mul_b = MB_W'(height_scale_reg);
            end
            M_PX0:
            begin
                mul_a = MA_W'(signed'({1'b0, x0_reg})) - MA_W'(signed'({1'b0, y0_reg}));
                mul_b = MB_W'(cos_angle_reg);
            end
            M_PY0:
            begin
                mul_a = MA_W'(signed'({1'b0, x0_reg})) + MA_W'(signed'({1'b0, y0_reg}));
                mul_b = MB_W'(sin_angle_reg);
            end
            M_PX1:
            begin
                mul_a = MA_W'(signed'({1'b0, x1_reg})) - MA_W'(signed'({1'b0, y1_reg}));
                mul_b = MB_W'(cos_angle_reg);
            end
            M_PY1:
            begin
                mul_a = MA_W'(signed'({1'b0, x1_reg})) + MA_W'(signed'({1'b0, y1_reg}));
                mul_b = MB_W'(sin_angle_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        mag_x = dx_reg[POS_W-1] ? POS_W'(-dx_reg) : POS_W'(dx_reg);
        mag_y = dy_reg[POS_W-1] ? POS_W'(-dy_reg) : POS_W'(dy_reg);
        mag_m = (mag_y > mag_x) ? mag_y : mag_x;
    end

    assign shift_xf = POS_W'(shift_x_reg) <<< FRAC_BITS;
    assign shift_yf = POS_W'(shift_y_reg) <<< FRAC_BITS;

    assign div_start    = ((state_reg == ST_DIVX) || (state_reg == ST_DIVY)) && !div_started_reg;
    assign div_dividend = (state_reg == ST_DIVX) ? mag_x : mag_y;
    assign quo_trunc    = div_quo[STEP_W-1:0];

    always_comb
    begin
        if (((state_reg == ST_DIVX) && dx_reg[POS_W-1])
            || ((state_reg == ST_DIVY) && dy_reg[POS_W-1]))
            step_new = -signed'(quo_trunc);
        else
            step_new = signed'(quo_trunc);
    end

    ielr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (span_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_size_reg    <= 8'd20;
            height_scale_reg <= 8'sd1;
            cos_angle_reg    <= 16'sd11415;
            sin_angle_reg    <= 16'sd11754;
            shift_x_reg      <= '0;
            shift_y_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_UNIT_SIZE:    unit_size_reg    <= cfg_data[7:0];
                REG_HEIGHT_SCALE: height_scale_reg <= signed'(cfg_data[7:0]);
                REG_COS_ANGLE:    cos_angle_reg    <= signed'(cfg_data);
                REG_SIN_ANGLE:    sin_angle_reg    <= signed'(cfg_data);
                REG_SHIFT_X:      shift_x_reg      <= signed'(cfg_data[12:0]);
                REG_SHIFT_Y:      shift_y_reg      <= signed'(cfg_data[12:0]);
                default:          ;
            endcase
        end
    end

    // Sequencer, walk state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            mstep_reg       <= M_X0;
            div_started_reg <= 1'b0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            step_x_reg      <= '0;
            step_y_reg      <= '0;
            left_reg        <= '0;
            edge_color_reg  <= COLOR_FLAT;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat && !cmd)
                    begin
                        mstep_reg <= M_X0;
                        state_reg <= ST_MUL;
                    end
                    else if (emit)
                    begin
                        out_valid_reg <= 1'b1;
                        pos_x_reg     <= pos_x_reg + POS_W'(step_x_reg);
                        pos_y_reg     <= pos_y_reg + POS_W'(step_y_reg);
                        left_reg      <= left_reg - SPAN_W'(1);
                    end
                end
                ST_MUL:
                begin
                    if (mstep_reg == M_PY1)
                        state_reg <= ST_ADD;
                    else
                        mstep_reg <= mstep_t'(mstep_reg + 4'd1);
                end
                ST_ADD:
                begin
                    pos_x_reg <= from_q14(ppx0_reg) + shift_xf;
                    pos_y_reg <= from_q14(ppy0_reg) - (POS_W'(z0_reg) <<< FRAC_BITS) + shift_yf;
                    edge_color_reg <= ((z0_reg != '0) || (z1_reg != '0)) ? COLOR_HEIGHT
                                                                           : COLOR_FLAT;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    state_reg <= ST_SPAN;
                end
                ST_SPAN:
                begin
                    // The span stays well below 2^22, so no clamp is needed.
                    if ((mag_m >> FRAC_BITS) == '0)
                    begin
                        step_x_reg <= '0;
                        step_y_reg <= '0;
                        left_reg   <= '0;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        div_started_reg <= 1'b0;
                        state_reg       <= ST_DIVX;
                    end
                end
                ST_DIVX:
                begin
                    if (div_done)
                    begin
                        step_x_reg      <= step_new;
                        div_started_reg <= 1'b0;
                        state_reg       <= ST_DIVY;
                    end
                    else
                        div_started_reg <= 1'b1;
                end
                ST_DIVY:
                begin
                    div_started_reg <= 1'b1;
                    if (div_done)
                    begin
                        step_y_reg <= step_new;
                        left_reg   <= span_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (in_beat && !cmd)
        begin
            col0_reg <= col_start;
            row0_reg <= row_start;
            col1_reg <= col_end;
            row1_reg <= row_end;
            h0_reg   <= height_start;
            h1_reg   <= height_end;
        end

        if (state_reg == ST_MUL)
        begin
            unique case (mstep_reg)
                M_X0:    x0_reg   <= prod[XS_W-1:0];
                M_Y0:    y0_reg   <= prod[XS_W-1:0];
                M_X1:    x1_reg   <= prod[XS_W-1:0];
                M_Y1:    y1_reg   <= prod[XS_W-1:0];
                M_Z0:    z0_reg   <= prod[ZS_W-1:0];
                M_Z1:    z1_reg   <= prod[ZS_W-1:0];
                M_PX0:   ppx0_reg <= prod;
                M_PY0:   ppy0_reg <= prod;
                M_PX1:   ppx1_reg <= prod;
                M_PY1:   ppy1_reg <= prod;
                default: ;
            endcase
        end

        if (state_reg == ST_ADD)
        begin
            end_x_reg <= from_q14(ppx1_reg) + shift_xf;
            end_y_reg <= from_q14(ppy1_reg) - (POS_W'(z1_reg) <<< FRAC_BITS) + shift_yf;
        end

        if (state_reg == ST_DIFF)
        begin
            dx_reg <= end_x_reg - pos_x_reg;
            dy_reg <= end_y_reg - pos_y_reg;
        end

        if (state_reg == ST_SPAN)
            span_reg <= SPAN_W'(mag_m >> FRAC_BITS);

        if (emit)
        begin
            pixel_x_reg <= pixel_coord(pos_x_reg);
            pixel_y_reg <= pixel_coord(pos_y_reg);
            color_reg   <= edge_color_reg;
            last_reg    <= (left_reg == SPAN_W'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = signed'(pixel_x_reg);
    assign pixel_y   = signed'(pixel_y_reg);
    assign color     = color_reg;
    assign last      = last_reg;

    `IELR_ASSERT_NOW(a_div_hidden, div_busy, !in_ready, "divider busy while input is ready")
    `IELR_ASSERT_NEXT(a_load_blocks, in_valid && in_ready && !cmd, !in_ready,
                      "input ready straight after an edge load")
    `IELR_ASSERT_NOW(a_pixel_from_tick, $rose(out_valid),
                     $past(in_valid && in_ready && cmd), "pixel without a tick beat")

endmodule

>>> hdl/ielr_div.sv
// ----------------------------------------------------------------------------
// ielr_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module ielr_div
    import ielr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [POS_W-1:0]  dividend,
    input  logic [SPAN_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [POS_W-1:0]  quotient
);

    logic [SPAN_W:0]   rem_reg;
    logic [POS_W-1:0]  quo_reg;
    logic [SPAN_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SPAN_W:0]   rem_sh;
    logic              fits;
    logic [SPAN_W:0]   rem_next;
    logic [POS_W-1:0]  quo_next;

    // The remainder stays below the divisor, so its top bit is always clear.
    always_comb
    begin
        rem_sh   = {rem_reg[SPAN_W-1:0], quo_reg[POS_W-1]};
        fits     = rem_sh >= {1'b0, div_reg};
        rem_next = fits ? rem_sh - {1'b0, div_reg} : rem_sh;
        quo_next = {quo_reg[POS_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(POS_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Isometric edge rasterizer testbench
// Loads grid edges under several projection settings and walks them pixel by
// pixel. A built-in predictor tracks the fixed-point walk, and every pixel beat
// is checked field by field against it. The run applies random idling on both
// channels, a long output stall, and a pause of the sender.
// ----------------------------------------------------------------------------
module testbench
    import ielr_pkg::*;
();

    localparam int  HALF_PERIOD = 10;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  SETTLE      = 150;     // longer than the slowest edge load
    localparam int  ONE_SHIFT   = FRAC_BITS;
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [9:0]        cs;
        logic [9:0]        rs;
        logic [9:0]        ce;
        logic [9:0]        re;
        logic signed [11:0] hs;
        logic signed [11:0] he;
    } grid_item_t;

    localparam int ITEM_W = $bits(grid_item_t);

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [23:0]           rgb;
        logic                  fin;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = 1'b0;
    logic [9:0] col_start = '0, row_start = '0, col_end = '0, row_end = '0;
    logic signed [11:0] height_start = '0, height_end = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [COORD_BITS-1:0] pixel_x, pixel_y;
    logic [23:0] color;
    logic last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Predictor copy of the registers and the walk state.
    logic [7:0]         p_unit = 8'd20;
    logic signed [7:0]  p_hscale = 8'sd1;
    logic signed [15:0] p_cos = 16'sd11415;
    logic signed [15:0] p_sin = 16'sd11754;
    logic signed [12:0] p_shx = '0;
    logic signed [12:0] p_shy = '0;
    longint walk_x = 0, walk_y = 0, inc_x = 0, inc_y = 0, pixels_left = 0;
    logic [23:0] edge_rgb = COLOR_FLAT;

    pixel_t pixel_q[$];
    int  n_items = 0, n_loads = 0, n_pixels = 0, n_writes = 0, n_errors = 0;
    int  cycles = 0;
    bit  gaps_on = 1'b1;
    bit  stall_on = 1'b1;
    int  long_hold = 0;
    int  stall_left = 0;

    isometric_edge_line_rasterizer_unit uut (.*);

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (long_hold > 0)
        begin
            long_hold--;
            out_ready <= 1'b0;
        end
        else if (!stall_on)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 18);
        end
    end

    always @(posedge clk)
    begin
        pixel_t exp_px;
        if (rst_n && out_valid && out_ready)
        begin
            n_pixels++;
            if (pixel_q.size() == 0)
            begin
                n_errors++;
                $error("pixel beat with none expected: x=%0d y=%0d", pixel_x, pixel_y);
            end
            else
            begin
                exp_px = pixel_q.pop_front();
                if (pixel_x !== exp_px.x)
                begin
                    n_errors++;
                    $error("pixel_x expected %0d got %0d", $signed(exp_px.x), pixel_x);
                end
                if (pixel_y !== exp_px.y)
                begin
                    n_errors++;
                    $error("pixel_y expected %0d got %0d", $signed(exp_px.y), pixel_y);
                end
                if (color !== exp_px.rgb)
                begin
                    n_errors++;
                    $error("color expected %h got %h", exp_px.rgb, color);
                end
                if (last !== exp_px.fin)
                begin
                    n_errors++;
                    $error("last expected %b got %b", exp_px.fin, last);
                end
            end
        end
    end

    function automatic longint to_frac(longint v);
        if (FRAC_BITS >= 14)
            return v * (longint'(1) <<< (FRAC_BITS - 14));
        return v / (longint'(1) <<< (14 - FRAC_BITS));
    endfunction

    function automatic logic [COORD_BITS-1:0] screen_coord(longint pos);
        longint v;
        longint hi;
        v  = pos / (longint'(1) <<< ONE_SHIFT);
        hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return v[COORD_BITS-1:0];
    endfunction

    // Projects a loaded edge, or advances the walk by one pixel on a tick.
    function automatic void project_and_walk(grid_item_t it);
        longint one, x0, y0, x1, y1, z0, z1, px0, py0, px1, py1, dx, dy, m, span;
        pixel_t p;
        one = longint'(1) <<< ONE_SHIFT;
        if (it.cmd == CMD_LOAD)
        begin
            x0 = longint'(it.cs) * longint'(p_unit);
            y0 = longint'(it.rs) * longint'(p_unit);
            x1 = longint'(it.ce) * longint'(p_unit);
            y1 = longint'(it.re) * longint'(p_unit);
            z0 = longint'(it.hs) * longint'(p_hscale);
            z1 = longint'(it.he) * longint'(p_hscale);
            edge_rgb = (z0 != 0 || z1 != 0) ? COLOR_HEIGHT : COLOR_FLAT;
            px0 = to_frac((x0 - y0) * longint'(p_cos)) + longint'(p_shx) * one;
            py0 = to_frac((x0 + y0) * longint'(p_sin)) - z0 * one + longint'(p_shy) * one;
            px1 = to_frac((x1 - y1) * longint'(p_cos)) + longint'(p_shx) * one;
            py1 = to_frac((x1 + y1) * longint'(p_sin)) - z1 * one + longint'(p_shy) * one;
            dx = px1 - px0;
            dy = py1 - py0;
            m  = (dx < 0) ? -dx : dx;
            if (((dy < 0) ? -dy : dy) > m)
                m = (dy < 0) ? -dy : dy;
            span = m / one;
            walk_x = px0;
            walk_y = py0;
            inc_x = (span > 0) ? dx / span : 0;
            inc_y = (span > 0) ? dy / span : 0;
            pixels_left = (span > 64'hffffff) ? 64'hffffff : span;
        end
        else if (pixels_left > 0)
        begin
            p.x = screen_coord(walk_x);
            p.y = screen_coord(walk_y);
            p.rgb = edge_rgb;
            p.fin = (pixels_left == 1);
            pixel_q.push_back(p);
            walk_x += inc_x;
            walk_y += inc_y;
            pixels_left--;
        end
    endfunction

    task automatic send_item(grid_item_t it);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= it.cmd;
        col_start    <= it.cs;
        row_start    <= it.rs;
        col_end      <= it.ce;
        row_end      <= it.re;
        height_start <= it.hs;
        height_end   <= it.he;
        do
            @(posedge clk);
        while (!in_ready);
        project_and_walk(it);
        n_items++;
        if (it.cmd == CMD_LOAD)
            n_loads++;
    endtask

    // The sender stops until every expected pixel has arrived and the block is idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        n_writes++;
        case (idx)
            REG_UNIT_SIZE:    p_unit   = val[7:0];
            REG_HEIGHT_SCALE: p_hscale = val[7:0];
            REG_COS_ANGLE:    p_cos    = val;
            REG_SIN_ANGLE:    p_sin    = val;
            REG_SHIFT_X:      p_shx    = val[12:0];
            REG_SHIFT_Y:      p_shy    = val[12:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_projection(int unit, int hsc, int cs, int sn, int shx, int shy);
        settle();
        write_reg(REG_UNIT_SIZE, 16'(unit));
        write_reg(REG_HEIGHT_SCALE, 16'(hsc));
        write_reg(REG_COS_ANGLE, 16'(cs));
        write_reg(REG_SIN_ANGLE, 16'(sn));
        write_reg(REG_SHIFT_X, 16'(shx));
        write_reg(REG_SHIFT_Y, 16'(shy));
    endtask

    function automatic grid_item_t edge_of(int cs, int rs, int ce, int re, int hs, int he);
        grid_item_t it;
        it.cmd = CMD_LOAD;
        it.cs = 10'(cs);
        it.rs = 10'(rs);
        it.ce = 10'(ce);
        it.re = 10'(re);
        it.hs = 12'(hs);
        it.he = 12'(he);
        return it;
    endfunction

    // Fields other than cmd are ignored on a tick, so they carry noise.
    function automatic grid_item_t tick_of();
        grid_item_t it;
        it = grid_item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
        it.cmd = CMD_TICK;
        return it;
    endfunction

    function automatic grid_item_t random_edge();
        int sz, mode;
        int h0, h1;
        sz   = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(1, 12);
        mode = $urandom_range(0, 3);
        h0 = 0;
        h1 = 0;
        if (mode == 1)
        begin
            h0 = int'($urandom_range(0, 40)) - 20;
            h1 = int'($urandom_range(0, 40)) - 20;
        end
        else if (mode == 2)
        begin
            h0 = int'($urandom_range(0, 4095)) - 2048;
            h1 = int'($urandom_range(0, 4095)) - 2048;
        end
        else if (mode == 3)
            h1 = int'($urandom_range(0, 8)) - 4;
        return edge_of($urandom_range(0, sz), $urandom_range(0, sz),
                       $urandom_range(0, sz), $urandom_range(0, sz), h0, h1);
    endfunction

    // Loads an edge and ticks through at most cap of its pixels, then a few more.
    task automatic walk_edge(grid_item_t it, int cap, int extra);
        int n;
        send_item(it);
        n = (pixels_left < cap) ? int'(pixels_left) : cap;
        repeat (n + extra) send_item(tick_of());
    endtask

    task automatic test_directed();
        send_item(tick_of());                            // tick before any edge
        walk_edge(edge_of(3, 3, 3, 3, 0, 0), 4, 2);      // zero-length edge
        walk_edge(edge_of(0, 0, 4, 1, 0, 0), 64, 2);     // flat edge, walk left unfinished
        walk_edge(edge_of(2, 5, 6, 1, 5, -3), 64, 1);    // raised edge
        walk_edge(edge_of(0, 0, 2, 2, 0, 1), 64, 0);     // one end raised
        walk_edge(edge_of(1023, 0, 0, 1023, 2047, -2048), 4, 0);
        // Loaded in the middle of a walk, then replaced again.
        walk_edge(edge_of(0, 1023, 1023, 0, -2048, 2047), 3, 0);
        walk_edge(edge_of(0, 0, 1, 0, 0, 0), 64, 1);
    endtask

    task automatic test_config_sweep();
        set_projection(1, -64, -16384, 16384, -4096, 4095);
        write_reg(3'd6, 16'hffff);                       // unused indexes are ignored
        write_reg(3'd7, 16'h1234);
        walk_edge(edge_of(5, 1, 0, 7, 3, -2), 48, 1);
        walk_edge(edge_of(1023, 1023, 0, 0, 0, 0), 5, 0);
        set_projection(255, 64, 16384, -16384, 4095, -4096);
        walk_edge(edge_of(0, 0, 1, 0, 0, 0), 30, 0);
        walk_edge(edge_of(1023, 0, 0, 1023, -2048, 2047), 5, 0);
        set_projection(7, 0, 0, 0, 0, 0);
        walk_edge(edge_of(4, 2, 9, 8, 100, -100), 8, 2);
        set_projection(20, 1, 11415, 11754, 0, 0);
    endtask

    task automatic test_backpressure();
        settle();
        send_item(edge_of(0, 0, 8, 0, 0, 0));
        long_hold = 400;
        repeat (60) send_item(tick_of());
        settle();
    endtask

    task automatic test_random(int target);
        grid_item_t it;
        while (n_items < target)
        begin
            if ($urandom_range(0, 24) == 0)
                set_projection(($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 40),
                               int'($urandom_range(0, 128)) - 64,
                               int'($urandom_range(0, 32768)) - 16384,
                               int'($urandom_range(0, 32768)) - 16384,
                               int'($urandom_range(0, 8191)) - 4096,
                               int'($urandom_range(0, 8191)) - 4096);
            else if ($urandom_range(0, 15) == 0)
                settle();
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: stray ticks and loads with a random start column and end row.
                it = random_edge();
                it.cs = 10'($urandom);
                it.re = 10'($urandom);
                send_item(($urandom_range(0, 1) == 0) ? tick_of() : it);
            end
            else
                walk_edge(random_edge(), ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5)
                                                                    : $urandom_range(1, 40),
                          $urandom_range(0, 2));
        end
    endtask

    task automatic test_full_rate();
        settle();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (4) walk_edge(random_edge(), 30, 1);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random(950);
        test_full_rate();
        settle();
        $display("Covered %0d items (%0d edge loads), %0d pixels checked, %0d register writes.",
                 n_items, n_loads, n_pixels, n_writes);
        if (pixel_q.size() != 0)
        begin
            n_errors++;
            $error("%0d expected pixels never arrived", pixel_q.size());
        end
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
